[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the handle table RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset
`define GHT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never occurs outside reset
`define GHT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/ght_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ght_pkg
// Types, codes and sizes shared by the generational handle table blocks.
// ---------------------------------------------------------------------------
package ght_pkg;

    localparam int SLOTS     = 256;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int REF_W     = 32;
    localparam int CAP_W     = 9;
    localparam int IDX_W     = 16;
    localparam int GEN_W     = 16;
    localparam int VAL_W     = 9;
    localparam int TYP_W     = 6;
    localparam int FUNC_W    = 3;
    localparam int STAT_W    = 2;

    // free-slot search: groups of sixteen slots
    localparam int GRP_SIZE  = 16;
    localparam int GRP_W     = $clog2(GRP_SIZE);
    localparam int NGRP      = SLOTS / GRP_SIZE;
    localparam int GSEL_W    = $clog2(NGRP);

    // decoupling queue
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [IDX_W-1:0] BAD_INDEX = 16'hFFFF;

    // request functions
    localparam logic [FUNC_W-1:0] FN_PUT     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_GET     = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SET     = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ    = 3'd4;

    // result status
    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_REJECT  = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  req_index;
        logic [VAL_W-1:0]  req_validation;
        logic [TYP_W-1:0]  req_type;
        logic [REF_W-1:0]  req_ref;
        logic [GEN_W-1:0]  new_generation;
        logic              new_active;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  handle_index;
        logic [VAL_W-1:0]  handle_validation;
        logic [TYP_W-1:0]  handle_type;
        logic              handle_active;
        logic [REF_W-1:0]  found_ref;
        logic [GEN_W-1:0]  slot_generation;
        logic              slot_active;
    } rsp_t;

    // classified request as held in the queue
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              in_range;
        logic [SLOT_W-1:0] slot;
        logic [VAL_W-1:0]  val;
        logic [TYP_W-1:0]  typ;
        logic [REF_W-1:0]  rref;
        logic [GEN_W-1:0]  ngen;
        logic              nact;
    } qent_t;

    // queue handshake between front and back
    typedef struct packed {
        logic  valid;
        qent_t ent;
    } qpush_t;

    typedef struct packed {
        logic  valid;
        logic  full;
        qent_t head;
    } qstat_t;

endpackage

[rtl/ght_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ght_front
// Holds the capacity register, accepts request beats and classifies them
// (function, index range check) before they enter the queue.
// ---------------------------------------------------------------------------
module ght_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  ght_pkg::req_t             req,
    input  logic                      cap_we,
    input  logic [ght_pkg::CAP_W-1:0] cap_wdata,
    input  logic                      q_full,
    output ght_pkg::qpush_t           push,
    output logic [ght_pkg::CAP_W-1:0] cap_eff
);
    import ght_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_next;

    // capacity register
    always_comb
    begin
        cap_next = cap_reg;
        if (cap_we)
        begin
            cap_next = cap_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(SLOTS);
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    // clamp capacity to the slot count
    assign cap_eff = (cap_reg > CAP_W'(SLOTS)) ? CAP_W'(SLOTS) : cap_reg;

    // stall while the queue is full
    assign req_stall = q_full;

    // classify the beat
    always_comb
    begin
        push.valid        = req_valid & ~q_full;
        push.ent.func     = req.func;
        push.ent.in_range = (req.req_index != BAD_INDEX)
                            && (req.req_index < IDX_W'(cap_eff));
        push.ent.slot     = req.req_index[SLOT_W-1:0];
        push.ent.val      = req.req_validation;
        push.ent.typ      = req.req_type;
        push.ent.rref     = req.req_ref;
        push.ent.ngen     = req.new_generation;
        push.ent.nact     = req.new_active;
    end

endmodule

[rtl/ght_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ght_queue
// Short FIFO of classified requests between the front and the back.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ght_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  ght_pkg::qpush_t push,
    input  logic            pop,
    output ght_pkg::qstat_t stat
);
    import ght_pkg::*;

    qent_t              ent_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic [Q_CNT_W-1:0] cnt_next;
    logic               do_push;
    logic               do_pop;

    assign do_push = push.valid && (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign do_pop  = pop && (cnt_reg != '0);

    // advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // store the beat
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= push.ent;
        end
    end

    assign stat.valid = (cnt_reg != '0);
    assign stat.full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign stat.head  = ent_reg[rd_ptr_reg];

    `GHT_ASSERT_NEVER(a_q_overfill, clk, rst_n, cnt_reg > Q_CNT_W'(Q_DEPTH), "queue count beyond depth")

endmodule

[rtl/ght_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ght_back
// Carries out queued requests against the slot store: slot memories,
// active flags, the touched count, the free-slot search and the result beat.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ght_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ght_pkg::qstat_t           qstat,
    output logic                      q_pop,
    input  logic [ght_pkg::CAP_W-1:0] cap_eff,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output ght_pkg::rsp_t             rsp
);
    import ght_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_SRCH = 3'd1;
    localparam logic [2:0] B_PICK = 3'd2;
    localparam logic [2:0] B_READ = 3'd3;
    localparam logic [2:0] B_EXEC = 3'd4;

    // slot memories
    logic [REF_W-1:0] ref_mem [SLOTS];
    logic [GEN_W-1:0] gen_mem [SLOTS];
    logic [TYP_W-1:0] typ_mem [SLOTS];

    // per-slot flags
    logic [SLOTS-1:0] seen_reg;
    logic [SLOTS-1:0] seen_next;
    logic [SLOTS-1:0] act_reg;
    logic [SLOTS-1:0] act_next;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    qent_t             cur_reg;
    qent_t             cur_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [CAP_W-1:0]  used_reg;
    logic [CAP_W-1:0]  used_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    rsp_t              res_reg;
    rsp_t              res_next;
    logic [NGRP-1:0]   grp_free_reg;
    logic [NGRP-1:0]   grp_free_next;
    logic [GRP_W-1:0]  grp_pos_reg [NGRP];
    logic [GRP_W-1:0]  grp_pos_next [NGRP];

    // registered read port
    logic [REF_W-1:0]  rd_ref_reg;
    logic [GEN_W-1:0]  rd_gen_reg;
    logic [TYP_W-1:0]  rd_typ_reg;
    logic              rd_seen_reg;
    logic              rd_act_reg;
    logic [SLOT_W-1:0] rd_addr;

    // write port
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [REF_W-1:0]  wr_ref;
    logic [GEN_W-1:0]  wr_gen;
    logic [TYP_W-1:0]  wr_typ;
    logic              wr_act;

    logic [REF_W-1:0]  q_ref;
    logic [GEN_W-1:0]  q_gen;
    logic [TYP_W-1:0]  q_typ;
    logic              res_free;
    logic              gen_match;
    logic [SLOTS-1:0]  elig;
    logic              pick_any;
    logic [GSEL_W-1:0] pick_g;
    qent_t             head;

    function automatic logic [GRP_W-1:0] first_set(input logic [GRP_SIZE-1:0] v);
        logic [GRP_W-1:0] pos;
        pos = '0;
        for (int k = GRP_SIZE - 1; k >= 0; k--)
        begin
            if (v[k])
            begin
                pos = GRP_W'(k);
            end
        end
        return pos;
    endfunction

    assign head     = qstat.head;
    assign res_free = !res_valid_reg || !rsp_stall;
    assign q_pop    = (state_reg == B_IDLE) && qstat.valid && res_free;

    // read address: queue head's slot (the next untouched slot for a put) while idle, chosen slot otherwise
    assign rd_addr = (state_reg != B_IDLE) ? slot_reg :
                     (head.func == FN_PUT) ? used_reg[SLOT_W-1:0] : head.slot;

    // slots never written read as zero
    assign q_ref = rd_seen_reg ? rd_ref_reg : '0;
    assign q_gen = rd_seen_reg ? rd_gen_reg : '0;
    assign q_typ = rd_seen_reg ? rd_typ_reg : '0;
    assign gen_match = rd_act_reg && (q_gen[VAL_W-1:0] == cur_reg.val);

    // eligible slots for the free-slot search
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            elig[i] = !act_reg[i] && (CAP_W'(i) < cap_eff);
        end
        for (int g = 0; g < NGRP; g++)
        begin
            grp_free_next[g] = |elig[g*GRP_SIZE +: GRP_SIZE];
            grp_pos_next[g]  = first_set(elig[g*GRP_SIZE +: GRP_SIZE]);
        end
    end

    // pick the lowest group holding a free slot
    always_comb
    begin
        pick_any = |grp_free_reg;
        pick_g   = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_free_reg[g])
            begin
                pick_g = GSEL_W'(g);
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        slot_next      = slot_reg;
        used_next      = used_reg;
        seen_next      = seen_reg;
        act_next       = act_reg;
        res_valid_next = res_valid_reg && rsp_stall;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = slot_reg;
        wr_ref         = '0;
        wr_gen         = '0;
        wr_typ         = '0;
        wr_act         = 1'b0;

        // default result beat: rejected
        begin
            rsp_t r;
            r                   = '0;
            r.status            = ST_REJECT;
            r.handle_index      = BAD_INDEX;
            if (state_reg == B_IDLE || state_reg == B_PICK || state_reg == B_EXEC)
            begin
                res_next = res_free ? r : res_reg;
            end
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_pop)
                begin
                    cur_next = head;
                    unique case (head.func)
                        FN_PUT:
                        begin
                            if (used_reg < cap_eff)
                            begin
                                slot_next  = used_reg[SLOT_W-1:0];
                                used_next  = used_reg + 1'b1;
                                state_next = B_EXEC;
                            end
                            else if (cap_eff == '0)
                            begin
                                res_next.status = ST_FULL;
                                res_valid_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = B_SRCH;
                            end
                        end
                        FN_RELEASE, FN_GET, FN_READ:
                        begin
                            if (head.in_range)
                            begin
                                slot_next  = head.slot;
                                state_next = B_EXEC;
                            end
                            else
                            begin
                                res_valid_next = 1'b1;
                            end
                        end
                        FN_SET:
                        begin
                            if (head.in_range)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = head.slot;
                                wr_ref  = head.rref;
                                wr_gen  = head.ngen;
                                wr_typ  = head.typ;
                                wr_act  = head.nact;
                                if ({1'b0, head.slot} + 1'b1 > used_reg)
                                begin
                                    used_next = {1'b0, head.slot} + 1'b1;
                                end
                                res_next.status = ST_DONE;
                            end
                            res_valid_next = 1'b1;
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            B_SRCH:
            begin
                state_next = B_PICK;
            end
            B_PICK:
            begin
                if (pick_any)
                begin
                    slot_next  = {pick_g, grp_pos_reg[pick_g]};
                    state_next = B_READ;
                end
                else
                begin
                    res_next.status = ST_FULL;
                    res_valid_next  = 1'b1;
                    state_next      = B_IDLE;
                end
            end
            B_READ:
            begin
                state_next = B_EXEC;
            end
            B_EXEC:
            begin
                state_next     = B_IDLE;
                res_valid_next = 1'b1;
                unique case (cur_reg.func)
                    FN_PUT:
                    begin
                        wr_en   = 1'b1;
                        wr_ref  = cur_reg.rref;
                        wr_gen  = q_gen;
                        wr_typ  = cur_reg.typ;
                        wr_act  = 1'b1;
                        res_next.status            = ST_DONE;
                        res_next.handle_index      = IDX_W'(slot_reg);
                        res_next.handle_validation = q_gen[VAL_W-1:0];
                        res_next.handle_type       = cur_reg.typ;
                        res_next.handle_active     = 1'b1;
                    end
                    FN_RELEASE:
                    begin
                        if (gen_match)
                        begin
                            wr_en   = 1'b1;
                            wr_ref  = '0;
                            wr_gen  = q_gen + 1'b1;
                            wr_typ  = q_typ;
                            wr_act  = 1'b0;
                            res_next.status = ST_DONE;
                        end
                    end
                    FN_GET:
                    begin
                        if (gen_match && (q_typ == cur_reg.typ))
                        begin
                            res_next.status    = ST_DONE;
                            res_next.found_ref = q_ref;
                        end
                    end
                    FN_READ:
                    begin
                        res_next.status          = ST_DONE;
                        res_next.found_ref       = q_ref;
                        res_next.slot_generation = q_gen;
                        res_next.slot_active     = rd_act_reg;
                    end
                    default:
                    begin
                        res_next.status = ST_REJECT;
                    end
                endcase
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        // flag updates follow the write port
        if (wr_en)
        begin
            seen_next[wr_addr] = 1'b1;
            act_next[wr_addr]  = wr_act;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            used_reg      <= '0;
            seen_reg      <= '0;
            act_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            seen_reg      <= seen_next;
            act_reg       <= act_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        slot_reg     <= slot_next;
        res_reg      <= res_next;
        grp_free_reg <= grp_free_next;
        grp_pos_reg  <= grp_pos_next;
    end

    // slot memories: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ref_mem[wr_addr] <= wr_ref;
            gen_mem[wr_addr] <= wr_gen;
            typ_mem[wr_addr] <= wr_typ;
        end
        rd_ref_reg  <= ref_mem[rd_addr];
        rd_gen_reg  <= gen_mem[rd_addr];
        rd_typ_reg  <= typ_mem[rd_addr];
        rd_seen_reg <= seen_reg[rd_addr];
        rd_act_reg  <= act_reg[rd_addr];
    end

    assign rsp_valid = res_valid_reg;
    assign rsp       = res_reg;

    `GHT_ASSERT(a_exec_slot_free, clk, rst_n, (state_reg == B_EXEC) |-> !res_valid_reg, "result register busy at execute")
    `GHT_ASSERT_NEVER(a_used_bound, clk, rst_n, used_reg > CAP_W'(SLOTS), "touched count beyond slot count")
    `GHT_ASSERT(a_put_success, clk, rst_n, (res_valid_reg && res_reg.handle_active) |-> (res_reg.status == ST_DONE && res_reg.handle_index < IDX_W'(SLOTS)), "bad handle on put")

endmodule

[rtl/generational_handle_table_unit.sv]
`timescale 1ns / 1ps
// Sequence: a set slot, a reject and a put at capacity zero are answered from the idle state;
//   a put on a fresh slot, release, get and read slot go on to execute after the registered
//   slot memory read; a put that searches the active flags passes search, pick, read and
//   execute, or ends at pick when the search finds no free slot. Set slot and rejects are
//   taken one per cycle unless the result is stalled; other requests hold the back until done.
// Reset: all slots read as zero at once (written and active flags cleared), touched count zero, capacity 256.
// ---------------------------------------------------------------------------
// generational_handle_table_unit
// Slot map handing out generation-checked handles: a front that takes and
// classifies request beats, a short queue, and a back that works on the store.
// ---------------------------------------------------------------------------
module generational_handle_table_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  ght_pkg::req_t             req,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output ght_pkg::rsp_t             rsp,
    input  logic                      cap_we,
    input  logic [ght_pkg::CAP_W-1:0] cap_wdata
);
    import ght_pkg::*;

    qpush_t           push;
    qstat_t           qstat;
    logic             q_pop;
    logic [CAP_W-1:0] cap_eff;

    // accept and classify
    ght_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cap_we    (cap_we),
        .cap_wdata (cap_wdata),
        .q_full    (qstat.full),
        .push      (push),
        .cap_eff   (cap_eff)
    );

    // decouple front and back
    ght_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (q_pop),
        .stat  (qstat)
    );

    // execute against the slot store
    ght_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .q_pop     (q_pop),
        .cap_eff   (cap_eff),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
